>>> src/matrix_multiply_1x4_tile_top_macros.svh
// Assertion macros used by the tile control file.
`ifndef MATRIX_MULTIPLY_1X4_TILE_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_1X4_TILE_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MM14_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define MM14_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/mm14_pkg.sv
// Types, constants and the saturating adder shared by the 1x4 tile files.
package mm14_pkg;

	localparam int unsigned TileColumns = 4;
	localparam int unsigned OpWidth     = 32;
	localparam int unsigned AccWidth    = 64;

	typedef logic signed [OpWidth-1:0]  op_t;
	typedef logic signed [AccWidth-1:0] acc_t;

	// Pipeline control handed from the controller to every column cell.
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en_out;
		logic v2;
		logic last2;
	} mm14_ctl_t;

	// Signed add that clamps to the 64-bit range instead of wrapping.
	function automatic acc_t sat_add(input acc_t x, input acc_t y);
		acc_t s;
		s = x + y;
		if ((x[AccWidth-1] == y[AccWidth-1]) && (s[AccWidth-1] != x[AccWidth-1])) begin
			s = x[AccWidth-1] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
		end
		return s;
	endfunction

endpackage

>>> src/mm14_cell.sv
// One column cell: multiply, saturating accumulate and final C update.
module mm14_cell import mm14_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mm14_ctl_t ctl,
	input  op_t       a_s1,
	input  op_t       b_col,
	input  acc_t      c_in,
	output acc_t      c_out
);

	op_t  b_s1;
	acc_t c_s1;
	acc_t prod_s2;
	acc_t c_s2;
	acc_t sum_s3;
	acc_t c_s3;
	acc_t acc_q;
	acc_t c_out_q;
	acc_t sum_next;

	assign sum_next = sat_add(acc_q, prod_s2);

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			b_s1 <= b_col;
			c_s1 <= c_in;
		end
		if (ctl.en2) begin
			prod_s2 <= acc_t'(a_s1) * acc_t'(b_s1);
			c_s2    <= c_s1;
		end
		if (ctl.en3) begin
			sum_s3 <= sum_next;
			c_s3   <= c_s2;
		end
		if (ctl.en_out) begin
			c_out_q <= sat_add(c_s3, sum_s3);
		end
	end

	// The running sum restarts from zero once a last word has been folded in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en3 && ctl.v2) begin
			acc_q <= ctl.last2 ? '0 : sum_next;
		end
	end

	assign c_out = c_out_q;

endmodule

>>> src/mm14_ctrl.sv
// Pipeline valid bits, stall chain and output valid for the 1x4 tile.
module mm14_ctrl import mm14_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_last,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output mm14_ctl_t ctl
);

	`include "matrix_multiply_1x4_tile_top_macros.svh"

	logic v1_q, v2_q, v3_q;
	logic last1_q, last2_q, last3_q;
	logic rsp_valid_q;
	logic en1, en2, en3, en_out;

	// Stage three only holds when a last word waits on a full output register.
	assign en_out = !rsp_valid_q || rsp_ready;
	assign en3    = !v3_q || !last3_q || en_out;
	assign en2    = !v2_q || en3;
	assign en1    = !v1_q || en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			last1_q     <= 1'b0;
			last2_q     <= 1'b0;
			last3_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q    <= req_valid;
				last1_q <= req_last;
			end
			if (en2) begin
				v2_q    <= v1_q;
				last2_q <= last1_q;
			end
			if (en3) begin
				v3_q    <= v2_q;
				last3_q <= last2_q;
			end
			if (en_out) begin
				rsp_valid_q <= v3_q && last3_q;
			end
		end
	end

	assign req_ready  = en1;
	assign rsp_valid  = rsp_valid_q;
	assign ctl.en1    = en1;
	assign ctl.en2    = en2;
	assign ctl.en3    = en3;
	assign ctl.en_out = en_out;
	assign ctl.v2     = v2_q;
	assign ctl.last2  = last2_q;

	`MM14_ASSERT_NOW(a_out_implies_s3, !en_out || en3, "output advance without stage 3 advance")
	`MM14_ASSERT_NOW(a_ready_when_drain, !en_out || req_ready, "input stalled while output drains")
	`MM14_ASSERT_NEXT(a_last_reaches_out, v3_q && last3_q && en_out, rsp_valid_q,
		"last word did not reach the output register")
	`MM14_ASSERT_NOW(a_rsp_from_last, !$rose(rsp_valid_q) || $past(v3_q && last3_q),
		"result raised without a last word in stage 3")

endmodule

>>> src/matrix_multiply_1x4_tile_top.sv
// Top level of the 1x4 GEMM tile: controller plus a row of four column cells.
//
// Usage: each request word carries one A element, four B elements, four old C
// values and last_term. Every word is multiplied into four running Q32.32 sums,
// one per column, with saturation on every add. The word flagged last_term
// produces one response word c_out0..3 = saturated C_old + sum, and the sums
// restart from zero for the next tile. Words that are not last give no response.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Path: a last word that is accepted passes the input register, multiplier register,
// accumulator stage and output register before it shows on rsp_valid.
// Throughput is one word per cycle unless a stalled response holds the pipeline,
// with one 32x32 multiply and two 64-bit saturating adds in each column cell.
// If the receiver stalls, the output register holds its word and words keep
// flowing until a last word reaches the accumulator stage; that word waits there,
// two more words fill the stages behind it, and then req_ready falls.
// Non-last words never block.
// Reset (arst_n low) empties the pipeline, drops any pending response and clears
// the four running sums to zero.
module matrix_multiply_1x4_tile_top import mm14_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic signed [31:0] a_elem,
	input  logic signed [31:0] b_col0,
	input  logic signed [31:0] b_col1,
	input  logic signed [31:0] b_col2,
	input  logic signed [31:0] b_col3,
	input  logic signed [63:0] c_in0,
	input  logic signed [63:0] c_in1,
	input  logic signed [63:0] c_in2,
	input  logic signed [63:0] c_in3,
	input  logic        last_term,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic signed [63:0] c_out0,
	output logic signed [63:0] c_out1,
	output logic signed [63:0] c_out2,
	output logic signed [63:0] c_out3
);

	mm14_ctl_t ctl;
	op_t       a_s1;
	op_t       b_vec [TileColumns];
	acc_t      c_vec [TileColumns];
	acc_t      o_vec [TileColumns];

	// The A element is shared by all four columns, so it is registered once here.
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			a_s1 <= a_elem;
		end
	end

	assign b_vec[0] = b_col0;
	assign b_vec[1] = b_col1;
	assign b_vec[2] = b_col2;
	assign b_vec[3] = b_col3;
	assign c_vec[0] = c_in0;
	assign c_vec[1] = c_in1;
	assign c_vec[2] = c_in2;
	assign c_vec[3] = c_in3;

	mm14_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_last  (last_term),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl)
	);

	for (genvar g = 0; g < TileColumns; g++) begin : g_col
		mm14_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.a_s1   (a_s1),
			.b_col  (b_vec[g]),
			.c_in   (c_vec[g]),
			.c_out  (o_vec[g])
		);
	end

	assign c_out0 = o_vec[0];
	assign c_out1 = o_vec[1];
	assign c_out2 = o_vec[2];
	assign c_out3 = o_vec[3];

endmodule
